/* design/wtsp_pkg.sv */
// Shared constants, codes and types of the world-to-screen projection block.
package wtsp_pkg;

   // Number format and matrix store.
   localparam int FRAC_BITS   = 16;
   localparam int STORE_WORDS = 12;
   localparam int INDEX_W     = 4;
   localparam int COORD_W     = 32;
   localparam int ROWS        = 3;
   localparam int COLS        = 4;
   localparam int ROW_X       = 0;
   localparam int ROW_Y       = 1;
   localparam int ROW_W       = 2;
   localparam int M6_INDEX    = 6;

   // Register widths.
   localparam int DIM_W    = 14;
   localparam int OFFSET_W = 11;
   localparam int THR_W    = 17;

   // Datapath widths.
   localparam int PROD_FULL_W = 2 * COORD_W;
   localparam int PROD_W      = PROD_FULL_W - FRAC_BITS;
   localparam int ACC_W       = PROD_W + 2;
   localparam int OFF_PROD_W  = COORD_W + OFFSET_W;
   localparam int SUM_W       = ACC_W + 2;
   localparam int SPLIT_W     = SUM_W / 2;
   localparam int LO_W        = SPLIT_W + DIM_W;
   localparam int HI_W        = SUM_W - SPLIT_W + DIM_W + 1;
   localparam int NUM_W       = HI_W + SPLIT_W;
   localparam int DEN_W       = ACC_W + 1;
   localparam int DIV_W       = NUM_W + 1;
   localparam int QUO_W       = 17;
   localparam int PIX_W       = 16;

   // Result lanes.
   localparam int LANES      = 3;
   localparam int LANE_X     = 0;
   localparam int LANE_LOWER = 1;
   localparam int LANE_UPPER = 2;

   // Pipeline depths.
   localparam int PRE_STAGES = 5;
   localparam int DIV_STAGES = QUO_W + 1;
   localparam int PIPE_DEPTH = PRE_STAGES + DIV_STAGES;

   // Queue between front and back.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Saturation limits.
   localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7fff;
   localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;
   localparam logic [QUO_W:0] NEG_LIMIT = 18'd32768;

   // Item kinds.
   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_PROJECT = 1'b1;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_OFFSET  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_OFFSET  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_W_THRESHOLD   = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [DIM_W-1:0]           RST_SCREEN_WIDTH  = 14'd1920;
   localparam logic [DIM_W-1:0]           RST_SCREEN_HEIGHT = 14'd1080;
   localparam logic signed [OFFSET_W-1:0] RST_LOWER_OFFSET  = -11'sd8;
   localparam logic signed [OFFSET_W-1:0] RST_UPPER_OFFSET  = 11'sd78;
   localparam logic [THR_W-1:0]           RST_W_THRESHOLD   = 17'd655;

   // One queued transaction: a matrix load or a point to project.
   typedef struct packed {
      logic                       is_load;
      logic [INDEX_W-1:0]         index;
      logic signed [COORD_W-1:0]  a;
      logic signed [COORD_W-1:0]  b;
      logic signed [COORD_W-1:0]  c;
   } wtsp_entry_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [DIM_W-1:0]           screen_width;
      logic [DIM_W-1:0]           screen_height;
      logic signed [OFFSET_W-1:0] lower_offset;
      logic signed [OFFSET_W-1:0] upper_offset;
      logic [THR_W-1:0]           w_threshold;
   } wtsp_cfg_type;

endpackage

/* design/wtsp_front.sv */
// Front end: accepts transactions, drops bad loads and queues the rest.
module wtsp_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_kind,
   input  logic [wtsp_pkg::INDEX_W-1:0]           req_matrix_index,
   input  logic signed [wtsp_pkg::COORD_W-1:0]    req_matrix_value,
   input  logic signed [wtsp_pkg::COORD_W-1:0]    req_point_x,
   input  logic signed [wtsp_pkg::COORD_W-1:0]    req_point_y,
   input  logic signed [wtsp_pkg::COORD_W-1:0]    req_point_z,
   input  logic                                   pop,
   output wtsp_pkg::wtsp_entry_type               head,
   output logic                                   head_valid
);

   wtsp_pkg::wtsp_entry_type fifo_ff [wtsp_pkg::FIFO_DEPTH];
   wtsp_pkg::wtsp_entry_type entry_in;
   logic [wtsp_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [wtsp_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [wtsp_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic keep;
   logic push;

   // A load beyond the store is dropped; everything else is queued.
   assign keep = (req_kind == wtsp_pkg::KIND_PROJECT) ||
                 (req_matrix_index < wtsp_pkg::INDEX_W'(wtsp_pkg::STORE_WORDS));
   assign req_ready = (count_ff != wtsp_pkg::FIFO_CNT_W'(wtsp_pkg::FIFO_DEPTH));
   assign push = req_valid && req_ready && keep;

   always_comb begin
      entry_in.is_load = (req_kind == wtsp_pkg::KIND_LOAD);
      entry_in.index   = req_matrix_index;
      entry_in.a       = entry_in.is_load ? req_matrix_value : req_point_x;
      entry_in.b       = req_point_y;
      entry_in.c       = req_point_z;
   end

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + wtsp_pkg::FIFO_PTR_W'(push);
      rd_ptr_in = rd_ptr_ff + wtsp_pkg::FIFO_PTR_W'(pop);
      count_in  = count_ff + wtsp_pkg::FIFO_CNT_W'(push) - wtsp_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign head       = fifo_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);

endmodule

/* design/wtsp_divider.sv */
// Pipelined restoring divider with floor rounding and 16-bit saturation, three lanes.
module wtsp_divider (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [wtsp_pkg::NUM_W-1:0]    num [wtsp_pkg::LANES],
   input  logic [wtsp_pkg::DEN_W-1:0]           den,
   output logic signed [wtsp_pkg::PIX_W-1:0]    pix [wtsp_pkg::LANES]
);

   logic [wtsp_pkg::DIV_W-1:0] rem_ff [wtsp_pkg::DIV_STAGES][wtsp_pkg::LANES];
   logic [wtsp_pkg::QUO_W-1:0] quo_ff [wtsp_pkg::DIV_STAGES][wtsp_pkg::LANES];
   logic                       neg_ff [wtsp_pkg::DIV_STAGES][wtsp_pkg::LANES];
   logic [wtsp_pkg::DEN_W-1:0] den_ff [wtsp_pkg::DIV_STAGES];
   logic [wtsp_pkg::NUM_W-1:0] mag_in [wtsp_pkg::LANES];

   // Split each numerator into sign and magnitude.
   always_comb begin
      for (int l = 0; l < wtsp_pkg::LANES; l++) begin
         mag_in[l] = num[l][wtsp_pkg::NUM_W-1] ? wtsp_pkg::NUM_W'(-num[l])
                                               : wtsp_pkg::NUM_W'(num[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0] <= den;
         for (int l = 0; l < wtsp_pkg::LANES; l++) begin
            neg_ff[0][l] <= num[l][wtsp_pkg::NUM_W-1];
            rem_ff[0][l] <= wtsp_pkg::DIV_W'(mag_in[l]);
            quo_ff[0][l] <= '0;
         end
      end
   end

   // One quotient bit per stage, most significant first. The top bit flags overflow.
   for (genvar j = 1; j < wtsp_pkg::DIV_STAGES; j++) begin : g_step
      localparam int SH = wtsp_pkg::DIV_STAGES - 1 - j;
      logic [wtsp_pkg::DIV_W-1:0] dsh;

      assign dsh = wtsp_pkg::DIV_W'(den_ff[j-1]) << SH;

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[j] <= den_ff[j-1];
            for (int l = 0; l < wtsp_pkg::LANES; l++) begin
               neg_ff[j][l] <= neg_ff[j-1][l];
               if (rem_ff[j-1][l] >= dsh) begin
                  rem_ff[j][l] <= rem_ff[j-1][l] - dsh;
                  quo_ff[j][l] <= quo_ff[j-1][l] | (wtsp_pkg::QUO_W'(1) << SH);
               end else begin
                  rem_ff[j][l] <= rem_ff[j-1][l];
                  quo_ff[j][l] <= quo_ff[j-1][l];
               end
            end
         end
      end
   end

   // Floor toward minus infinity for negative numerators, then saturate.
   always_comb begin
      logic [wtsp_pkg::QUO_W-1:0] q;
      logic [wtsp_pkg::QUO_W:0]   t;
      for (int l = 0; l < wtsp_pkg::LANES; l++) begin
         q = quo_ff[wtsp_pkg::DIV_STAGES-1][l];
         t = {1'b0, q} +
             (wtsp_pkg::QUO_W+1)'(rem_ff[wtsp_pkg::DIV_STAGES-1][l] != '0);
         if (!neg_ff[wtsp_pkg::DIV_STAGES-1][l]) begin
            pix[l] = (q[wtsp_pkg::QUO_W-1] || q[wtsp_pkg::QUO_W-2])
                     ? wtsp_pkg::PIX_MAX : signed'(wtsp_pkg::PIX_W'(q));
         end else begin
            pix[l] = (q[wtsp_pkg::QUO_W-1] || (t > wtsp_pkg::NEG_LIMIT))
                     ? wtsp_pkg::PIX_MIN : signed'(wtsp_pkg::PIX_W'(-t));
         end
      end
   end

endmodule

/* design/wtsp_back.sv */
// Back end: matrix store, dot products, viewport scaling, divide and result register.
module wtsp_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wtsp_pkg::wtsp_cfg_type               cfg,
   input  wtsp_pkg::wtsp_entry_type             head,
   input  logic                                 head_valid,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_visible,
   output logic signed [wtsp_pkg::PIX_W-1:0]    rsp_screen_x,
   output logic signed [wtsp_pkg::PIX_W-1:0]    rsp_screen_y_lower,
   output logic signed [wtsp_pkg::PIX_W-1:0]    rsp_screen_y_upper
);

   logic pipe_en;
   logic project;

   logic signed [wtsp_pkg::COORD_W-1:0]     mat_ff [wtsp_pkg::STORE_WORDS];
   logic signed [wtsp_pkg::COORD_W-1:0]     coord [wtsp_pkg::COLS-1];
   logic signed [wtsp_pkg::PROD_FULL_W-1:0] prod_in [wtsp_pkg::ROWS][wtsp_pkg::COLS-1];
   logic signed [wtsp_pkg::OFF_PROD_W-1:0]  offl_in, offu_in;

   // Stage 1 registers.
   logic signed [wtsp_pkg::PROD_W-1:0]     prod_ff [wtsp_pkg::ROWS][wtsp_pkg::COLS-1];
   logic signed [wtsp_pkg::COORD_W-1:0]    const_ff [wtsp_pkg::ROWS];
   logic signed [wtsp_pkg::OFF_PROD_W-1:0] offl_ff, offu_ff;
   // Stage 2 registers.
   logic signed [wtsp_pkg::ACC_W-1:0]      acc_in [wtsp_pkg::ROWS];
   logic signed [wtsp_pkg::ACC_W-1:0]      acc_ff [wtsp_pkg::ROWS];
   logic signed [wtsp_pkg::OFF_PROD_W-1:0] offl2_ff, offu2_ff;
   // Stage 3 registers.
   logic signed [wtsp_pkg::SUM_W-1:0]      sum_in [wtsp_pkg::LANES];
   logic signed [wtsp_pkg::SUM_W-1:0]      sum_ff [wtsp_pkg::LANES];
   logic signed [wtsp_pkg::ACC_W-1:0]      w3_ff;
   logic [wtsp_pkg::DEN_W-1:0]             d3_ff;
   logic                                   vis_in;
   // Stage 4 registers.
   logic [wtsp_pkg::DIM_W-1:0]             scale [wtsp_pkg::LANES];
   logic [wtsp_pkg::LO_W-1:0]              lo_in [wtsp_pkg::LANES];
   logic signed [wtsp_pkg::HI_W-1:0]       hi_in [wtsp_pkg::LANES];
   logic [wtsp_pkg::LO_W-1:0]              lo_ff [wtsp_pkg::LANES];
   logic signed [wtsp_pkg::HI_W-1:0]       hi_ff [wtsp_pkg::LANES];
   logic signed [wtsp_pkg::ACC_W-1:0]      w4_ff;
   logic [wtsp_pkg::DEN_W-1:0]             d4_ff;
   // Stage 5 registers.
   logic signed [wtsp_pkg::NUM_W-1:0]      num_in [wtsp_pkg::LANES];
   logic signed [wtsp_pkg::NUM_W-1:0]      num_ff [wtsp_pkg::LANES];
   logic [wtsp_pkg::DEN_W-1:0]             d5_ff;
   logic signed [wtsp_pkg::PIX_W-1:0]      pix [wtsp_pkg::LANES];

   // Valid and visible flags that ride along the pipeline.
   logic [wtsp_pkg::PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic [wtsp_pkg::PIPE_DEPTH-3:0] vis_ff, vis_pipe_in;

   logic                              rsp_valid_ff, rsp_visible_ff;
   logic signed [wtsp_pkg::PIX_W-1:0] rsp_x_ff, rsp_yl_ff, rsp_yu_ff;

   // The whole back end advances together whenever the result register is empty or rsp_ready is high.
   assign pipe_en = !rsp_valid_ff || rsp_ready;
   assign pop     = pipe_en && head_valid;
   assign project = pop && !head.is_load;

   // Loads update the store in queue order, so later points see them.
   always_ff @(posedge clock) begin
      if (pop && head.is_load) begin
         mat_ff[head.index] <= head.a;
      end
   end

   // Stage 1: all row products and the two offset products.
   assign coord[0] = head.a;
   assign coord[1] = head.b;
   assign coord[2] = head.c;

   always_comb begin
      for (int r = 0; r < wtsp_pkg::ROWS; r++) begin
         for (int c = 0; c < wtsp_pkg::COLS - 1; c++) begin
            prod_in[r][c] = mat_ff[r * wtsp_pkg::COLS + c] * coord[c];
         end
      end
   end

   assign offl_in = mat_ff[wtsp_pkg::M6_INDEX] * cfg.lower_offset;
   assign offu_in = mat_ff[wtsp_pkg::M6_INDEX] * cfg.upper_offset;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int r = 0; r < wtsp_pkg::ROWS; r++) begin
            for (int c = 0; c < wtsp_pkg::COLS - 1; c++) begin
               prod_ff[r][c] <= prod_in[r][c][wtsp_pkg::PROD_FULL_W-1:wtsp_pkg::FRAC_BITS];
            end
            const_ff[r] <= mat_ff[r * wtsp_pkg::COLS + wtsp_pkg::COLS - 1];
         end
         offl_ff <= offl_in;
         offu_ff <= offu_in;
      end
   end

   // Stage 2: row sums give clip x, clip y and clip w.
   always_comb begin
      for (int r = 0; r < wtsp_pkg::ROWS; r++) begin
         acc_in[r] = wtsp_pkg::ACC_W'(const_ff[r]) + wtsp_pkg::ACC_W'(prod_ff[r][0]) +
                     wtsp_pkg::ACC_W'(prod_ff[r][1]) + wtsp_pkg::ACC_W'(prod_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         acc_ff   <= acc_in;
         offl2_ff <= offl_ff;
         offu2_ff <= offu_ff;
      end
   end

   // Stage 3: numerator bases, divisor 2w and the visibility test.
   always_comb begin
      sum_in[wtsp_pkg::LANE_X] = wtsp_pkg::SUM_W'(acc_ff[wtsp_pkg::ROW_W]) +
                                 wtsp_pkg::SUM_W'(acc_ff[wtsp_pkg::ROW_X]);
      sum_in[wtsp_pkg::LANE_LOWER] = wtsp_pkg::SUM_W'(acc_ff[wtsp_pkg::ROW_W]) -
                                     wtsp_pkg::SUM_W'(acc_ff[wtsp_pkg::ROW_Y]) -
                                     wtsp_pkg::SUM_W'(offl2_ff);
      sum_in[wtsp_pkg::LANE_UPPER] = wtsp_pkg::SUM_W'(acc_ff[wtsp_pkg::ROW_W]) -
                                     wtsp_pkg::SUM_W'(acc_ff[wtsp_pkg::ROW_Y]) -
                                     wtsp_pkg::SUM_W'(offu2_ff);
      vis_in = acc_ff[wtsp_pkg::ROW_W] >
               wtsp_pkg::ACC_W'(signed'({1'b0, cfg.w_threshold}));
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sum_ff <= sum_in;
         w3_ff  <= acc_ff[wtsp_pkg::ROW_W];
         d3_ff  <= {acc_ff[wtsp_pkg::ROW_W], 1'b0};
      end
   end

   // Stage 4: scale by width or height as two narrow partial products.
   assign scale[wtsp_pkg::LANE_X]     = cfg.screen_width;
   assign scale[wtsp_pkg::LANE_LOWER] = cfg.screen_height;
   assign scale[wtsp_pkg::LANE_UPPER] = cfg.screen_height;

   always_comb begin
      for (int l = 0; l < wtsp_pkg::LANES; l++) begin
         lo_in[l] = wtsp_pkg::LO_W'(scale[l]) *
                    wtsp_pkg::LO_W'(sum_ff[l][wtsp_pkg::SPLIT_W-1:0]);
         hi_in[l] = wtsp_pkg::HI_W'(signed'({1'b0, scale[l]})) *
                    wtsp_pkg::HI_W'(signed'(sum_ff[l][wtsp_pkg::SUM_W-1:wtsp_pkg::SPLIT_W]));
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         w4_ff <= w3_ff;
         d4_ff <= d3_ff;
      end
   end

   // Stage 5: recombine partial products; screen x also adds w for rounding.
   always_comb begin
      for (int l = 0; l < wtsp_pkg::LANES; l++) begin
         num_in[l] = (wtsp_pkg::NUM_W'(hi_ff[l]) <<< wtsp_pkg::SPLIT_W) +
                     wtsp_pkg::NUM_W'(lo_ff[l]) +
                     ((l == wtsp_pkg::LANE_X) ? wtsp_pkg::NUM_W'(w4_ff) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         num_ff <= num_in;
         d5_ff  <= d4_ff;
      end
   end

   wtsp_divider u_divider (
      .clock (clock),
      .en    (pipe_en),
      .num   (num_ff),
      .den   (d5_ff),
      .pix   (pix)
   );

   // Control flags along the pipeline.
   assign vld_in      = {vld_ff[wtsp_pkg::PIPE_DEPTH-2:0], project};
   assign vis_pipe_in = {vis_ff[wtsp_pkg::PIPE_DEPTH-4:0], vis_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         vis_ff <= vis_pipe_in;
      end
   end

   // Result register; a hidden point reports all zeros.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= vld_ff[wtsp_pkg::PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_visible_ff <= vis_ff[wtsp_pkg::PIPE_DEPTH-3];
         rsp_x_ff  <= vis_ff[wtsp_pkg::PIPE_DEPTH-3] ? pix[wtsp_pkg::LANE_X] : '0;
         rsp_yl_ff <= vis_ff[wtsp_pkg::PIPE_DEPTH-3] ? pix[wtsp_pkg::LANE_LOWER] : '0;
         rsp_yu_ff <= vis_ff[wtsp_pkg::PIPE_DEPTH-3] ? pix[wtsp_pkg::LANE_UPPER] : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_visible        = rsp_visible_ff;
   assign rsp_screen_x       = rsp_x_ff;
   assign rsp_screen_y_lower = rsp_yl_ff;
   assign rsp_screen_y_upper = rsp_yu_ff;

endmodule

/* design/world_to_screen_projection.sv */
// Top level of the world-to-screen projection block: configuration registers and wiring.
// Throughput: one transaction per cycle while no result waits on rsp_ready;
// a load takes one back-end slot and gives no result. The depth is the queue, five
// multiply and add stages, the 18-stage divider and the result register.
// A four-entry queue keeps accepting while a result waits on rsp_ready.
// Reset clears the queue and pipeline; matrix words hold no value until loaded.
module world_to_screen_projection (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [wtsp_pkg::INDEX_W-1:0]          req_matrix_index,
   input  logic signed [wtsp_pkg::COORD_W-1:0]   req_matrix_value,
   input  logic signed [wtsp_pkg::COORD_W-1:0]   req_point_x,
   input  logic signed [wtsp_pkg::COORD_W-1:0]   req_point_y,
   input  logic signed [wtsp_pkg::COORD_W-1:0]   req_point_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_visible,
   output logic signed [wtsp_pkg::PIX_W-1:0]     rsp_screen_x,
   output logic signed [wtsp_pkg::PIX_W-1:0]     rsp_screen_y_lower,
   output logic signed [wtsp_pkg::PIX_W-1:0]     rsp_screen_y_upper,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wtsp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wtsp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   wtsp_pkg::wtsp_cfg_type   cfg_ff;
   wtsp_pkg::wtsp_entry_type head;
   logic head_valid;
   logic pop;
   logic csr_write;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= wtsp_pkg::RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= wtsp_pkg::RST_SCREEN_HEIGHT;
         cfg_ff.lower_offset  <= wtsp_pkg::RST_LOWER_OFFSET;
         cfg_ff.upper_offset  <= wtsp_pkg::RST_UPPER_OFFSET;
         cfg_ff.w_threshold   <= wtsp_pkg::RST_W_THRESHOLD;
      end else if (csr_write) begin
         case (csr_index)
            wtsp_pkg::CSR_SCREEN_WIDTH: begin
               cfg_ff.screen_width <= csr_wdata[wtsp_pkg::DIM_W-1:0];
            end
            wtsp_pkg::CSR_SCREEN_HEIGHT: begin
               cfg_ff.screen_height <= csr_wdata[wtsp_pkg::DIM_W-1:0];
            end
            wtsp_pkg::CSR_LOWER_OFFSET: begin
               cfg_ff.lower_offset <= signed'(csr_wdata[wtsp_pkg::OFFSET_W-1:0]);
            end
            wtsp_pkg::CSR_UPPER_OFFSET: begin
               cfg_ff.upper_offset <= signed'(csr_wdata[wtsp_pkg::OFFSET_W-1:0]);
            end
            wtsp_pkg::CSR_W_THRESHOLD: begin
               cfg_ff.w_threshold <= csr_wdata[wtsp_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   wtsp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_matrix_index (req_matrix_index),
      .req_matrix_value (req_matrix_value),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .pop              (pop),
      .head             (head),
      .head_valid       (head_valid)
   );

   wtsp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .head               (head),
      .head_valid         (head_valid),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_visible        (rsp_visible),
      .rsp_screen_x       (rsp_screen_x),
      .rsp_screen_y_lower (rsp_screen_y_lower),
      .rsp_screen_y_upper (rsp_screen_y_upper)
   );

endmodule

/* tb/wtsp_checker.sv */
// Checker for the world-to-screen projection block: predicts every result and compares it.
module wtsp_checker
   import wtsp_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_kind,
   input  logic [INDEX_W-1:0]              req_matrix_index,
   input  logic signed [COORD_W-1:0]       req_matrix_value,
   input  logic signed [COORD_W-1:0]       req_point_x,
   input  logic signed [COORD_W-1:0]       req_point_y,
   input  logic signed [COORD_W-1:0]       req_point_z,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_visible,
   input  logic signed [PIX_W-1:0]         rsp_screen_x,
   input  logic signed [PIX_W-1:0]         rsp_screen_y_lower,
   input  logic signed [PIX_W-1:0]         rsp_screen_y_upper,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [CSR_INDEX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]           csr_wdata,
   output int                              error_count,
   output int                              outstanding
);

   typedef struct packed {
      logic                    visible;
      logic signed [PIX_W-1:0] sx;
      logic signed [PIX_W-1:0] syl;
      logic signed [PIX_W-1:0] syu;
   } pixel_type;

   // Shadow copy of the matrix words and the configuration registers.
   logic signed [COORD_W-1:0]  mat_word [STORE_WORDS];
   logic [DIM_W-1:0]           shadow_width;
   logic [DIM_W-1:0]           shadow_height;
   logic signed [OFFSET_W-1:0] shadow_lower;
   logic signed [OFFSET_W-1:0] shadow_upper;
   logic [THR_W-1:0]           shadow_thr;
   pixel_type                  expected_pixels[$];

   // One row of the matrix times (x, y, z, 1), each product floored to the fraction.
   function automatic longint row_sum(int base, longint x, longint y, longint z);
      longint acc;
      acc = longint'(mat_word[base + 3]);
      acc += (longint'(mat_word[base]) * x) >>> FRAC_BITS;
      acc += (longint'(mat_word[base + 1]) * y) >>> FRAC_BITS;
      acc += (longint'(mat_word[base + 2]) * z) >>> FRAC_BITS;
      return acc;
   endfunction

   // floor(k * s / d) with the nonnegative remainder.
   function automatic logic signed [127:0] scaled_div(logic [DIM_W-1:0] k, longint s,
                                                      longint d,
                                                      output logic signed [127:0] rem);
      logic signed [127:0] num;
      logic signed [127:0] den;
      logic signed [127:0] quo;
      num = 128'(s) * $signed({114'd0, k});
      den = 128'(d);
      quo = num / den;
      rem = num - quo * den;
      if (rem < 0) begin
         quo = quo - 1;
         rem = rem + den;
      end
      return quo;
   endfunction

   function automatic logic signed [PIX_W-1:0] clamp_pixel(logic signed [127:0] v);
      if (v > 32767) return PIX_MAX;
      if (v < -32768) return PIX_MIN;
      return v[PIX_W-1:0];
   endfunction

   // Expected result of projecting one point with the current matrix and registers.
   function automatic pixel_type project_point(longint x, longint y, longint z);
      pixel_type           res;
      longint              w, cx, c1, cl, cu, m6;
      logic signed [127:0] q;
      logic signed [127:0] rem;
      res = '0;
      w = row_sum(8, x, y, z);
      if (w <= longint'({47'd0, shadow_thr})) return res;
      cx = row_sum(0, x, y, z);
      c1 = row_sum(4, x, y, z);
      m6 = longint'(mat_word[M6_INDEX]);
      cl = c1 + m6 * longint'(shadow_lower);
      cu = c1 + m6 * longint'(shadow_upper);
      // Screen x is rounded half up; both y values are floored.
      q = scaled_div(shadow_width, w + cx, 2 * w, rem);
      if (rem >= 128'(w)) q = q + 1;
      res.visible = 1'b1;
      res.sx  = clamp_pixel(q);
      res.syl = clamp_pixel(scaled_div(shadow_height, w - cl, 2 * w, rem));
      res.syu = clamp_pixel(scaled_div(shadow_height, w - cu, 2 * w, rem));
      return res;
   endfunction

   // Watch all three channels at each rising edge.
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         foreach (mat_word[i]) mat_word[i] = '0;
         shadow_width  = RST_SCREEN_WIDTH;
         shadow_height = RST_SCREEN_HEIGHT;
         shadow_lower  = RST_LOWER_OFFSET;
         shadow_upper  = RST_UPPER_OFFSET;
         shadow_thr    = RST_W_THRESHOLD;
         expected_pixels.delete();
         error_count = 0;
      end else begin
         // Register write transaction.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  shadow_width  = csr_wdata[DIM_W-1:0];
               CSR_SCREEN_HEIGHT: shadow_height = csr_wdata[DIM_W-1:0];
               CSR_LOWER_OFFSET:  shadow_lower  = csr_wdata[OFFSET_W-1:0];
               CSR_UPPER_OFFSET:  shadow_upper  = csr_wdata[OFFSET_W-1:0];
               CSR_W_THRESHOLD:   shadow_thr    = csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
         // Result transaction against the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result: visible %0b x %0d yl %0d yu %0d",
                           rsp_visible, rsp_screen_x, rsp_screen_y_lower,
                           rsp_screen_y_upper);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_visible !== want.visible || rsp_screen_x !== want.sx ||
                   rsp_screen_y_lower !== want.syl || rsp_screen_y_upper !== want.syu)
               begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: expected %0b %0d %0d %0d, got %0b %0d %0d %0d",
                              want.visible, want.sx, want.syl, want.syu, rsp_visible,
                              rsp_screen_x, rsp_screen_y_lower, rsp_screen_y_upper);
               end
            end
         end
         // Input transaction: load a word or queue a projection.
         if (req_valid && req_ready) begin
            if (req_kind == KIND_LOAD) begin
               if (req_matrix_index < STORE_WORDS)
                  mat_word[req_matrix_index] = req_matrix_value;
            end else begin
               expected_pixels.push_back(project_point(longint'(req_point_x),
                                                       longint'(req_point_y),
                                                       longint'(req_point_z)));
            end
         end
      end
      outstanding = expected_pixels.size();
   end

endmodule

/* tb/tb_world_to_screen_projection.sv */
// Testbench top for the world-to-screen projection block: stimulus, clock and verdict.
module tb_world_to_screen_projection;
   import wtsp_pkg::*;

   localparam int ONE = 65536;
   // An index that names no register.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_kind = KIND_LOAD;
   logic [INDEX_W-1:0]          req_matrix_index = '0;
   logic signed [COORD_W-1:0]   req_matrix_value = '0;
   logic signed [COORD_W-1:0]   req_point_x = '0;
   logic signed [COORD_W-1:0]   req_point_y = '0;
   logic signed [COORD_W-1:0]   req_point_z = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_visible;
   logic signed [PIX_W-1:0]     rsp_screen_x;
   logic signed [PIX_W-1:0]     rsp_screen_y_lower;
   logic signed [PIX_W-1:0]     rsp_screen_y_upper;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;
   int                          error_count;
   int                          outstanding;
   logic                        burst = 1'b0;

   world_to_screen_projection DUT (.*);
   wtsp_checker checker_inst (.*);

   always #10 clock = ~clock;

   // Idle cycles before the next transaction; none during a burst.
   function automatic int draw_gap();
      return burst ? 0 : $urandom_range(0, 13);
   endfunction

   // Offer one input item and wait until it is accepted.
   task automatic push_item(logic kind, logic [INDEX_W-1:0] idx, logic [31:0] val,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int  gap;
      logic hit;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_matrix_index <= idx;
      req_matrix_value <= val;
      req_point_x      <= x;
      req_point_y      <= y;
      req_point_z      <= z;
      do begin
         @(negedge clock);
         hit = req_ready;
         @(posedge clock);
      end while (!hit);
   endtask

   task automatic load_word(int idx, logic [31:0] val);
      push_item(KIND_LOAD, idx[INDEX_W-1:0], val, $urandom, $urandom, $urandom);
   endtask

   task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      push_item(KIND_PROJECT, INDEX_W'($urandom), $urandom, x, y, z);
   endtask

   // Register write transaction.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      logic hit;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(negedge clock);
         hit = csr_ready;
         @(posedge clock);
      end while (!hit);
      csr_valid <= 1'b0;
   endtask

   // Hold the sender until every expected result is back, then let loads drain.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] modest_word();
      return $urandom_range(0, 8 * ONE) - 4 * ONE;
   endfunction

   function automatic logic [31:0] modest_coord();
      return $urandom_range(0, 2000 * ONE) - 1000 * ONE;
   endfunction

   // A fresh, mostly well-behaved matrix with a non-negative depth term.
   task automatic load_random_matrix();
      for (int i = 0; i < STORE_WORDS; i++) begin
         if (i == 11) load_word(i, $urandom_range(0, 500 * ONE));
         else if ($urandom_range(0, 9) == 0) load_word(i, $urandom);
         else load_word(i, modest_word());
      end
   endtask

   // Result side: random stalls between result transactions.
   initial begin
      int  gap;
      logic hit;
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(negedge clock);
            hit = rsp_valid;
            @(posedge clock);
         end while (!hit);
      end
   end

   // Toggle stretches without any idling.
   initial begin
      forever begin
         repeat ($urandom_range(200, 600)) @(posedge clock);
         burst <= ~burst;
      end
   end

   // Run limit.
   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      logic [CSR_DATA_W-1:0] reg_vals [6][5];
      int r;
      reg_vals[0] = '{1920, 1080, 17'h7f8, 78, 655};
      reg_vals[1] = '{8192, 8192, 17'h400, 1023, 0};
      reg_vals[2] = '{1, 1, 1023, 17'h400, 65536};
      reg_vals[3] = '{0, 0, 0, 0, 17'h1ffff};
      reg_vals[4] = '{CSR_DATA_W'($urandom_range(1, 8192)),
                      CSR_DATA_W'($urandom_range(1, 8192)),
                      CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                      CSR_DATA_W'($urandom_range(0, 65536))};
      reg_vals[5] = '{640, 480, 17'h7f8, 78, 655};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: simple camera where x maps to x, z to screen y and y is depth.
      for (int i = 0; i < STORE_WORDS; i++) load_word(i, 0);
      load_word(0, ONE);
      load_word(6, ONE);
      load_word(9, ONE);
      load_word(12, 32'h7fffffff);
      load_word(15, 32'h80000000);
      project(10 * ONE, 100 * ONE, 5 * ONE);
      project(0, 0, 0);
      project(ONE, 655, 0);
      project(ONE, 656, 0);
      project(32'h7fffffff, 656, 32'h80000000);
      project(32'h80000000, 32'h7fffffff, 32'h7fffffff);
      project(32'hffffffff, 32'h80000000, 32'hffffffff);
      project(-3 * ONE, 2 * ONE, -ONE);
      project(ONE / 2, ONE, ONE / 2);

      for (int p = 0; p < 6; p++) begin
         drain();
         if (p == 3) write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
         write_reg(CSR_SCREEN_WIDTH, reg_vals[p][0]);
         write_reg(CSR_SCREEN_HEIGHT, reg_vals[p][1]);
         write_reg(CSR_LOWER_OFFSET, reg_vals[p][2]);
         write_reg(CSR_UPPER_OFFSET, reg_vals[p][3]);
         write_reg(CSR_W_THRESHOLD, reg_vals[p][4]);
         load_random_matrix();
         for (int n = 0; n < 290; n++) begin
            r = $urandom_range(0, 99);
            if (r < 6) load_word($urandom_range(0, 11), modest_word());
            else if (r < 8) load_word($urandom_range(0, 11), $urandom);
            else if (r < 11) load_word($urandom_range(12, 15), $urandom);
            else if (r < 80) project(modest_coord(), modest_coord(), modest_coord());
            else project($urandom, $urandom, $urandom);
         end
      end

      drain();
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

/* sim.f */
design/wtsp_pkg.sv
design/wtsp_front.sv
design/wtsp_divider.sv
design/wtsp_back.sv
design/world_to_screen_projection.sv
tb/wtsp_checker.sv
tb/tb_world_to_screen_projection.sv
